// ===== rtl/core/jsu_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and constants for the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

    localparam int JOB_BYTES  = 5;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = FIFO_AW + 1;

    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_U         = 8'h75;
    localparam logic [7:0] CHAR_QMARK     = 8'h3F;
    localparam logic [7:0] CHAR_SLASH     = 8'h2F;
    localparam logic [7:0] CHAR_DQUOTE    = 8'h22;
    localparam logic [7:0] CHAR_N         = 8'h6E;
    localparam logic [7:0] CHAR_T         = 8'h74;
    localparam logic [7:0] CHAR_R         = 8'h72;
    localparam logic [7:0] CHAR_B         = 8'h62;
    localparam logic [7:0] CHAR_F         = 8'h66;

    // output bytes caused by one input beat
    typedef struct packed {
        logic [JOB_BYTES-1:0][7:0] bytes;
        logic [2:0]                count;
        logic                      last;
    } t_job;

    typedef struct packed {
        logic full;
        logic valid;
    } t_fifo_stat;

endpackage
`default_nettype wire

// ===== rtl/core/jsu_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_front
// Accepts raw bytes, tracks escape state and builds the output job per beat.
// ----------------------------------------------------------------------------
module jsu_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [7:0]       i_in_byte,
    input  wire logic             i_in_last,
    input  wire jsu_pkg::t_fifo_stat i_fifo_stat,
    output logic                  o_full,
    output logic                  o_job_wr,
    output jsu_pkg::t_job         o_job
);

    typedef enum logic [1:0] {
        MODE_NORMAL,
        MODE_ESCAPE,
        MODE_HEX
    } t_mode;

    t_mode       r_mode, n_mode;
    logic [1:0]  r_hex_cnt, n_hex_cnt;
    logic [7:0]  r_pend [3];
    logic        pend_we;
    logic        accept;
    logic [7:0]  tail0, tail1, tail2;
    jsu_pkg::t_job job;

    function automatic jsu_pkg::t_job add(input jsu_pkg::t_job j, input logic [7:0] b);
        jsu_pkg::t_job r;
        r = j;
        r.bytes[r.count] = b;
        r.count = r.count + 3'd1;
        return r;
    endfunction

    function automatic jsu_pkg::t_job add_esc(input jsu_pkg::t_job j, input logic [7:0] c);
        logic [7:0] m;
        logic       hit;
        hit = 1'b1;
        m   = c;
        unique case (c)
            jsu_pkg::CHAR_N:         m = 8'h0A;
            jsu_pkg::CHAR_T:         m = 8'h09;
            jsu_pkg::CHAR_R:         m = 8'h0D;
            jsu_pkg::CHAR_B:         m = 8'h08;
            jsu_pkg::CHAR_F:         m = 8'h0C;
            jsu_pkg::CHAR_DQUOTE,
            jsu_pkg::CHAR_BACKSLASH,
            jsu_pkg::CHAR_SLASH:     m = c;
            default:                 hit = 1'b0;
        endcase
        if (hit) begin
            return add(j, m);
        end
        return add(add(j, jsu_pkg::CHAR_BACKSLASH), c);
    endfunction

    assign accept   = i_push && !i_fifo_stat.full;
    assign o_full   = i_fifo_stat.full;
    assign o_job    = job;
    assign o_job_wr = accept && (job.count != 3'd0);

    // short \u tail: collected bytes, then the final byte
    assign tail0 = (r_hex_cnt == 2'd0) ? i_in_byte : r_pend[0];
    assign tail1 = (r_hex_cnt == 2'd1) ? i_in_byte : r_pend[1];
    assign tail2 = i_in_byte;

    always_comb begin
        n_mode    = r_mode;
        n_hex_cnt = r_hex_cnt;
        pend_we   = 1'b0;
        job       = '0;
        unique case (r_mode)
            MODE_ESCAPE: begin
                if (i_in_byte == jsu_pkg::CHAR_U && !i_in_last) begin
                    n_mode    = MODE_HEX;
                    n_hex_cnt = 2'd0;
                end else begin
                    job    = add_esc(job, i_in_byte);
                    n_mode = MODE_NORMAL;
                end
            end
            MODE_HEX: begin
                if (r_hex_cnt == 2'd3) begin
                    job       = add(job, jsu_pkg::CHAR_QMARK);
                    n_mode    = MODE_NORMAL;
                    n_hex_cnt = 2'd0;
                end else if (i_in_last) begin
                    job = add(job, jsu_pkg::CHAR_BACKSLASH);
                    job = add(job, jsu_pkg::CHAR_U);
                    unique case (r_hex_cnt)
                        2'd0: job = add(job, tail0);
                        2'd1: begin
                            if (tail0 == jsu_pkg::CHAR_BACKSLASH) begin
                                job = add_esc(job, tail1);
                            end else begin
                                job = add(add(job, tail0), tail1);
                            end
                        end
                        default: begin
                            if (tail0 == jsu_pkg::CHAR_BACKSLASH) begin
                                job = add(add_esc(job, tail1), tail2);
                            end else if (tail1 == jsu_pkg::CHAR_BACKSLASH) begin
                                job = add_esc(add(job, tail0), tail2);
                            end else begin
                                job = add(add(add(job, tail0), tail1), tail2);
                            end
                        end
                    endcase
                end else begin
                    pend_we   = 1'b1;
                    n_hex_cnt = r_hex_cnt + 2'd1;
                end
            end
            default: begin
                if (i_in_byte == jsu_pkg::CHAR_BACKSLASH && !i_in_last) begin
                    n_mode = MODE_ESCAPE;
                end else begin
                    job = add(job, i_in_byte);
                end
            end
        endcase
        if (i_in_last) begin
            n_mode    = MODE_NORMAL;
            n_hex_cnt = 2'd0;
        end
        job.last = i_in_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_NORMAL;
            r_hex_cnt <= 2'd0;
        end else if (accept) begin
            r_mode    <= n_mode;
            r_hex_cnt <= n_hex_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && pend_we) begin
            r_pend[r_hex_cnt] <= i_in_byte;
        end
    end

    // hex count only runs while collecting after \u
    a_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode != MODE_HEX) |-> (r_hex_cnt == 2'd0))
        else $error("hex count set outside hex mode");

endmodule
`default_nettype wire

// ===== rtl/core/jsu_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_fifo
// Short job queue between front and back.
// ----------------------------------------------------------------------------
module jsu_fifo (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_wr,
    input  wire jsu_pkg::t_job    i_wr_data,
    input  wire logic             i_rd,
    output jsu_pkg::t_job         o_rd_data,
    output jsu_pkg::t_fifo_stat   o_stat
);

    jsu_pkg::t_job                 r_mem [jsu_pkg::FIFO_DEPTH];
    logic [jsu_pkg::FIFO_AW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [jsu_pkg::FIFO_CW-1:0]   r_count;
    logic                          do_wr, do_rd;

    assign o_stat.full  = (r_count == jsu_pkg::FIFO_CW'(jsu_pkg::FIFO_DEPTH));
    assign o_stat.valid = (r_count != '0);
    assign o_rd_data    = r_mem[r_rd_ptr];
    assign do_wr        = i_wr && !o_stat.full;
    assign do_rd        = i_rd && o_stat.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= jsu_pkg::FIFO_CW'(jsu_pkg::FIFO_DEPTH))
        else $error("job queue overfilled");

    a_wr_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_wr |=> o_stat.valid)
        else $error("job queue empty after write");

endmodule
`default_nettype wire

// ===== rtl/core/jsu_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_back
// Serialises queued jobs into single output bytes, one byte per cycle while pop is high.
// ----------------------------------------------------------------------------
module jsu_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire jsu_pkg::t_job    i_job,
    input  wire jsu_pkg::t_fifo_stat i_fifo_stat,
    output logic                  o_job_rd,
    input  wire logic             pop,
    output logic                  empty,
    output logic [7:0]            o_out_byte,
    output logic                  o_out_last
);

    jsu_pkg::t_job r_job;
    logic [2:0]    r_idx;
    logic          r_valid;
    logic          at_end;
    logic          load;

    assign at_end     = (r_idx == (r_job.count - 3'd1));
    assign load       = !r_valid || (pop && at_end);
    assign o_job_rd   = load && i_fifo_stat.valid;
    assign empty      = !r_valid;
    assign o_out_byte = r_job.bytes[r_idx];
    assign o_out_last = r_job.last && at_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 3'd0;
        end else if (load) begin
            r_valid <= i_fifo_stat.valid;
            r_idx   <= 3'd0;
        end else if (pop) begin
            r_idx <= r_idx + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_rd) begin
            r_job <= i_job;
        end
    end

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_job.count != 3'd0 && r_idx < r_job.count))
        else $error("output index beyond job");

endmodule
`default_nettype wire

// ===== rtl/core/json_string_unescaper.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// json_string_unescaper
// Unescapes the body of a JSON string, one raw byte in and up to five out.
// ----------------------------------------------------------------------------
// Input side is a queue: drive i_in_byte/i_in_last and raise push; the beat
// is taken when full is low. Output side is a queue too: while empty is low
// the oldest byte is on o_out_byte/o_out_last, and pop takes it.
// One input beat is taken per cycle while the job queue has room. Each beat
// makes zero to five output bytes, sent one per cycle while pop is high; with
// the output stage idle, the first byte of a beat is written to the job queue
// and then loaded into the output stage register. Sustained rate is one input
// beat per cycle while pop is high and the beats average one output byte or
// fewer; longer bursts (escape tails, short \u at end of string) fill the
// four-entry job queue and raise full until the output side catches up.
// When pop stays low, bytes wait in the output stage and the job queue, and
// full rises once the queue is full; nothing is lost.
// Synchronous reset empties the queue and returns to plain copying mode.
// ----------------------------------------------------------------------------
module json_string_unescaper (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_in_last,
    input  wire logic       pop,
    output logic            empty,
    output logic [7:0]      o_out_byte,
    output logic            o_out_last
);

    jsu_pkg::t_fifo_stat fifo_stat;
    jsu_pkg::t_job       wr_job, rd_job;
    logic                job_wr, job_rd;

    jsu_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_in_byte   (i_in_byte),
        .i_in_last   (i_in_last),
        .i_fifo_stat (fifo_stat),
        .o_full      (full),
        .o_job_wr    (job_wr),
        .o_job       (wr_job)
    );

    jsu_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (job_wr),
        .i_wr_data (wr_job),
        .i_rd      (job_rd),
        .o_rd_data (rd_job),
        .o_stat    (fifo_stat)
    );

    jsu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (rd_job),
        .i_fifo_stat (fifo_stat),
        .o_job_rd    (job_rd),
        .pop         (pop),
        .empty       (empty),
        .o_out_byte  (o_out_byte),
        .o_out_last  (o_out_last)
    );

endmodule
`default_nettype wire
